>>> hw/rtl/mlta_pkg.sv
// ----------------------------------------------------------------------------
// MAC learning table package
// Request and result types, operation and register codes, reset values.
// ----------------------------------------------------------------------------
package mlta_pkg;

    localparam int MAC_W       = 48;
    localparam int PORT_W      = 4;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0]  AGING_RESET = 32'd300;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EXPIRATION = 1'd0,
        REG_LIMIT      = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [MAC_W-1:0]  mac_addr;
        logic [PORT_W-1:0] port_in;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [PORT_W-1:0]  port_out;
        logic               learned;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic               hit;
        logic               live;
        logic [PORT_W-1:0]  port;
        logic               free;
    } chain_t;

    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        logic [1:0]        operation;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] now;
        logic              alloc_ok;
    } ctrl_t;

endpackage

>>> hw/rtl/mlta_cell.sv
// ----------------------------------------------------------------------------
// MAC learning table cell
// One table entry: compares against the request, passes hit, port and
// free-slot status to its neighbor, and updates itself on learn or lookup.
// ----------------------------------------------------------------------------
module mlta_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  mlta_pkg::ctrl_t  ctrl,
    input  mlta_pkg::chain_t chain_in,
    output mlta_pkg::chain_t chain_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          live_reg;
    logic                          live_next;
    logic [mlta_pkg::MAC_W-1:0]    mac_reg;
    logic [mlta_pkg::MAC_W-1:0]    mac_next;
    logic [mlta_pkg::PORT_W-1:0]   port_reg;
    logic [mlta_pkg::PORT_W-1:0]   port_next;
    logic [mlta_pkg::TIME_W-1:0]   expiry_reg;
    logic [mlta_pkg::TIME_W-1:0]   expiry_next;
    logic                          store_new;
    logic                          refresh;
    logic                          drop;

    assign chain_out.hit  = chain_in.hit | hit_reg;
    assign chain_out.live = chain_in.live | (hit_reg & live_reg);
    assign chain_out.port = hit_reg ? port_reg : chain_in.port;
    assign chain_out.free = chain_in.free | ~valid_reg;

    always_comb
    begin
        store_new = ctrl.upd_en && (ctrl.operation == mlta_pkg::OP_LEARN) && ctrl.alloc_ok
                    && !chain_in.free && !valid_reg;
        refresh   = ctrl.upd_en && (ctrl.operation == mlta_pkg::OP_LEARN) && hit_reg;
        drop      = ctrl.upd_en && (ctrl.operation == mlta_pkg::OP_LOOKUP) && hit_reg
                    && !live_reg;

        valid_next  = valid_reg;
        mac_next    = mac_reg;
        port_next   = port_reg;
        expiry_next = expiry_reg;
        hit_next    = hit_reg;
        live_next   = live_reg;

        if (ctrl.cmp_en)
        begin
            hit_next  = valid_reg && (mac_reg == ctrl.mac);
            live_next = expiry_reg > ctrl.now;
        end
        if (store_new)
        begin
            valid_next = 1'b1;
            mac_next   = ctrl.mac;
        end
        if (store_new || refresh)
        begin
            port_next   = ctrl.port;
            expiry_next = ctrl.expiry;
        end
        if (drop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg    <= mac_next;
        port_reg   <= port_next;
        expiry_reg <= expiry_next;
    end

endmodule

>>> hw/rtl/mac_learning_table_aging_unit.sv
// ----------------------------------------------------------------------------
// MAC learning table with aging
// Learn, lookup and tick requests over a chain of entry cells.
// ----------------------------------------------------------------------------
// A taken request runs the compare then update state; done is registered in the update state.
// busy is high for the compare cycle
// and a new request may be taken during the update cycle.
// The compare cycle matches all cells; the update cycle ripples hit and
// free-slot status down the cell chain. Reset empties the table, clears time.
// The receiver cannot stall; done is a one-cycle strobe.
module mac_learning_table_aging_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mlta_pkg::request_t                  request,
    input  logic                                cfg_write,
    input  logic [mlta_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mlta_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output mlta_pkg::result_t                   result
);

    localparam int HELD_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (HELD_W > mlta_pkg::COUNT_W) ? HELD_W : mlta_pkg::COUNT_W;

    mlta_pkg::state_t                 state_reg;
    mlta_pkg::state_t                 state_next;
    mlta_pkg::request_t               req_reg;
    mlta_pkg::request_t               req_next;
    logic [mlta_pkg::TIME_W-1:0]      time_reg;
    logic [mlta_pkg::TIME_W-1:0]      time_next;
    logic [mlta_pkg::TIME_W-1:0]      aging_reg;
    logic [mlta_pkg::TIME_W-1:0]      aging_next;
    logic [mlta_pkg::COUNT_W-1:0]     limit_reg;
    logic [mlta_pkg::COUNT_W-1:0]     limit_next;
    logic [mlta_pkg::TIME_W-1:0]      expiry_reg;
    logic [mlta_pkg::TIME_W-1:0]      expiry_next;
    logic [HELD_W-1:0]                held_reg;
    logic [HELD_W-1:0]                held_next;
    logic                             done_reg;
    logic                             done_next;
    mlta_pkg::result_t                result_reg;
    mlta_pkg::result_t                result_next;

    logic [mlta_pkg::TIME_W:0]        expiry_sum;
    logic                             accept;
    logic                             is_learn;
    logic                             is_lookup;
    logic                             room;
    logic                             alloc;
    logic                             drop;
    mlta_pkg::chain_t                 tail;
    mlta_pkg::ctrl_t                  ctrl;
    mlta_pkg::chain_t                 chain [0:TABLE_DEPTH];

    assign accept    = start && !busy;
    assign busy      = (state_reg == mlta_pkg::ST_CMP);
    assign done      = done_reg;
    assign result    = result_reg;
    assign is_learn  = (req_reg.operation == mlta_pkg::OP_LEARN);
    assign is_lookup = (req_reg.operation == mlta_pkg::OP_LOOKUP);
    assign tail      = chain[TABLE_DEPTH];
    assign chain[0]  = '0;

    assign expiry_sum = {1'b0, time_reg} + {1'b0, aging_reg};
    assign room = (CMP_W'(held_reg) < CMP_W'(limit_reg))
               && (CMP_W'(held_reg) < CMP_W'(TABLE_DEPTH));
    assign alloc = is_learn && !tail.hit && room && tail.free;
    assign drop  = is_lookup && tail.hit && !tail.live;

    always_comb
    begin
        ctrl.cmp_en    = (state_reg == mlta_pkg::ST_CMP);
        ctrl.upd_en    = (state_reg == mlta_pkg::ST_UPD);
        ctrl.operation = req_reg.operation;
        ctrl.mac       = req_reg.mac_addr;
        ctrl.port      = req_reg.port_in;
        ctrl.expiry    = expiry_reg;
        ctrl.now       = time_reg;
        ctrl.alloc_ok  = !tail.hit && room;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        mlta_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        time_next   = time_reg;
        aging_next  = aging_reg;
        limit_next  = limit_reg;
        expiry_next = expiry_reg;
        held_next   = held_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                mlta_pkg::REG_EXPIRATION: aging_next = cfg_data;
                mlta_pkg::REG_LIMIT:      limit_next = cfg_data[mlta_pkg::COUNT_W-1:0];
                default:                  aging_next = aging_reg;
            endcase
        end

        if (accept)
        begin
            req_next = request;
        end

        unique case (state_reg)
            mlta_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mlta_pkg::ST_CMP;
                end
            end
            mlta_pkg::ST_CMP:
            begin
                expiry_next = expiry_sum[mlta_pkg::TIME_W] ? '1
                                                           : expiry_sum[mlta_pkg::TIME_W-1:0];
                state_next  = mlta_pkg::ST_UPD;
            end
            mlta_pkg::ST_UPD:
            begin
                if (alloc)
                begin
                    held_next = held_reg + HELD_W'(1);
                end
                else if (drop && (held_reg != '0))
                begin
                    held_next = held_reg - HELD_W'(1);
                end
                if ((req_reg.operation == mlta_pkg::OP_TICK) && (time_reg != '1))
                begin
                    time_next = time_reg + mlta_pkg::TIME_W'(1);
                end
                done_next               = 1'b1;
                result_next.found       = is_lookup && tail.hit && tail.live;
                result_next.port_out    = (is_lookup && tail.hit && tail.live) ? tail.port : '0;
                result_next.learned     = is_learn && (tail.hit || alloc);
                result_next.entry_count = mlta_pkg::COUNT_W'(held_next);
                state_next              = accept ? mlta_pkg::ST_CMP : mlta_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlta_pkg::ST_IDLE;
            time_reg  <= '0;
            aging_reg <= mlta_pkg::AGING_RESET;
            limit_reg <= mlta_pkg::LIMIT_RESET;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg  <= time_next;
            aging_reg <= aging_next;
            limit_reg <= limit_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        expiry_reg <= expiry_next;
        result_reg <= result_next;
    end

endmodule

>>> hw/rtl/mlta_checker.sv
// ----------------------------------------------------------------------------
// MAC learning table port checker
// Timing and result consistency checks on the top-level ports.
// ----------------------------------------------------------------------------
module mlta_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input mlta_pkg::result_t  result
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("result strobe missing three cycles after request");

    a_found_learned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.found && result.learned))
        else $error("result both found and learned");

    a_miss_port: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.port_out == '0)
        else $error("port reported on a miss");

endmodule

bind mac_learning_table_aging_unit mlta_checker u_mlta_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
